// ===== rtl/sliding_window_rate_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rate meter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_RATE_METER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SWRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swrm assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SWRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swrm assertion failed");
`else
`define SWRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SWRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/swrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rate meter package
// Shared widths, window geometry, divider sizing and cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

  // Window geometry
  localparam int WINDOW_SLOTS = 8;
  localparam int OLDER_SLOTS  = WINDOW_SLOTS - 1;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int STEP_W       = $clog2(WINDOW_SLOTS + 1);

  // Field widths
  localparam int TIME_W      = 32;
  localparam int SIZE_W      = 32;
  localparam int HIT_W       = 32;
  localparam int BYTE_W      = 48;
  localparam int FRAC_W      = 8;
  localparam int HIT_RATE_W  = 40;
  localparam int BYTE_RATE_W = 56;
  localparam int TOTAL_W     = 64;

  // Sums over the older buckets
  localparam int HIT_SUM_W  = HIT_W + SLOT_W;
  localparam int BYTE_SUM_W = BYTE_W + SLOT_W;

  // Constant divider: several quotient bits per cycle
  localparam int DIV_DIGITS = 8;
  localparam int DIV_CYCLES = (BYTE_SUM_W + FRAC_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DIV_W      = DIV_CYCLES * DIV_DIGITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);
  localparam int REM_W      = SLOT_W;
  localparam logic [REM_W:0] DIVISOR = OLDER_SLOTS[REM_W:0];

  // Control for one window cell
  typedef struct packed {
    logic shift;  // load from the neighbor
    logic add;    // add one hit of size_i
  } swrm_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/swrm_if.sv =====
// ----------------------------------------------------------------------------
// Rate meter channels
// Valid/ready interfaces for the event beat and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swrm_in_if import swrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] now_seconds;
  logic [SIZE_W-1:0] byte_count;

  modport source (output valid, output kind, output now_seconds, output byte_count,
                  input ready);
  modport sink   (input valid, input kind, input now_seconds, input byte_count,
                  output ready);
endinterface

interface swrm_out_if import swrm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HIT_RATE_W-1:0]  hit_rate;
  logic [BYTE_RATE_W-1:0] byte_rate;
  logic [TOTAL_W-1:0]     total_hits;
  logic [TOTAL_W-1:0]     total_bytes;

  modport source (output valid, output hit_rate, output byte_rate, output total_hits,
                  output total_bytes, input ready);
  modport sink   (input valid, input hit_rate, input byte_rate, input total_hits,
                  input total_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/swrm_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// One per-second bucket pair; loads from its neighbor or takes a saturating hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_cell import swrm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swrm_cell_ctrl_t   ctrl_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [HIT_W-1:0]  hit_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic [HIT_W-1:0]  hit_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic [HIT_W-1:0]  hit_q, hit_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [BYTE_W:0]   byte_sum;

  assign byte_sum = {1'b0, byte_q} + (BYTE_W + 1)'(size_i);

  always_comb begin
    hit_d  = hit_q;
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      hit_d  = hit_i;
      byte_d = byte_i;
    end else if (ctrl_i.add) begin
      // saturate both buckets
      if (hit_q != '1) hit_d = hit_q + HIT_W'(1);
      byte_d = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      byte_q <= '0;
    end else begin
      hit_q  <= hit_d;
      byte_q <= byte_d;
    end
  end

  assign hit_o  = hit_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== rtl/swrm_cdiv.sv =====
// ----------------------------------------------------------------------------
// Constant divider
// Long division by the older-slot count, DIV_DIGITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_cdiv import swrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic [DIV_W-1:0]     work_q, work_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  // Dividend bits leave at the top, quotient bits enter at the bottom.
  always_comb begin
    logic [REM_W:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int j = 0; j < DIV_DIGITS; j++) begin
      trial  = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (trial >= DIVISOR) begin
        work_d[0] = 1'b1;
        rem_d     = REM_W'(trial - DIVISOR);
      end else begin
        rem_d = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) done_q <= 1'b1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_rate_meter.sv =====
// ----------------------------------------------------------------------------
// Sliding window rate meter: a beat passes the aging steps (0..WINDOW_SLOTS),
// one pass of the cell chain and the dividers before its result is registered.
// A new beat is taken only after the previous one is through the cell chain and dividers.
// Reset (async, active low) clears buckets, last second, totals and control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_rate_meter_macros.svh"

module sliding_window_rate_meter import swrm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  swrm_in_if.sink   in_i,
  swrm_out_if.source out_o
);

  // Sequencer phases:
  //   ST_IDLE  take a beat, work out the aging distance
  //   ST_AGE   shift the chain one slot per cycle, zero enters at the newest cell
  //   ST_HIT   add the hit to the newest cell and to the totals
  //   ST_SUM   rotate the chain once around, summing every bucket but the newest
  //   ST_DIV   wait on the dividers and a free result register, then load it
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_HIT,
    ST_SUM,
    ST_DIV
  } state_e;

  state_e                 state_q;
  logic [STEP_W-1:0]      step_q;
  logic [SLOT_W-1:0]      rot_q;
  logic                   kind_q;
  logic [SIZE_W-1:0]      size_q;
  logic [TIME_W-1:0]      last_q;
  logic [TOTAL_W-1:0]     hit_total_q;
  logic [TOTAL_W-1:0]     byte_total_q;
  logic [HIT_SUM_W-1:0]   hit_acc_q;
  logic [BYTE_SUM_W-1:0]  byte_acc_q;
  logic                   out_valid_q;
  logic [HIT_RATE_W-1:0]  hit_rate_q;
  logic [BYTE_RATE_W-1:0] byte_rate_q;
  logic [TOTAL_W-1:0]     tot_hits_q;
  logic [TOTAL_W-1:0]     tot_bytes_q;

  logic in_hs;
  logic out_free;
  logic last_rot;

  // Aging distance for the incoming beat
  logic [TIME_W-1:0] elapsed;
  logic              later;
  logic [STEP_W-1:0] age_steps;

  assign in_hs    = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign last_rot = (rot_q == SLOT_W'(WINDOW_SLOTS - 1));
  assign elapsed  = in_i.now_seconds - last_q;
  assign later    = in_i.now_seconds > last_q;

  always_comb begin
    age_steps = '0;
    if (later) begin
      // cap the jump at the window: a full flush
      if (elapsed >= TIME_W'(WINDOW_SLOTS)) age_steps = STEP_W'(WINDOW_SLOTS);
      else age_steps = elapsed[STEP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 is the current second, the last cell the oldest.
  // --------------------------------------------------------------------------
  logic [HIT_W-1:0]  hit_chain  [WINDOW_SLOTS];
  logic [BYTE_W-1:0] byte_chain [WINDOW_SLOTS];
  logic [HIT_W-1:0]  hit_head;
  logic [BYTE_W-1:0] byte_head;
  logic              chain_shift;

  assign chain_shift = (state_q == ST_AGE) || (state_q == ST_SUM);
  // Aging feeds zeros in; the summing pass closes the ring.
  assign hit_head  = (state_q == ST_SUM) ? hit_chain[WINDOW_SLOTS-1]  : '0;
  assign byte_head = (state_q == ST_SUM) ? byte_chain[WINDOW_SLOTS-1] : '0;

  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
    swrm_cell_ctrl_t ctrl;
    logic [HIT_W-1:0]  hit_in;
    logic [BYTE_W-1:0] byte_in;

    assign ctrl.shift = chain_shift;
    if (i == 0) begin : g_head
      assign ctrl.add = (state_q == ST_HIT) && !kind_q;
      assign hit_in   = hit_head;
      assign byte_in  = byte_head;
    end else begin : g_body
      assign ctrl.add = 1'b0;
      assign hit_in   = hit_chain[i-1];
      assign byte_in  = byte_chain[i-1];
    end

    swrm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .size_i (size_q),
      .hit_i  (hit_in),
      .byte_i (byte_in),
      .hit_o  (hit_chain[i]),
      .byte_o (byte_chain[i])
    );
  end

  // --------------------------------------------------------------------------
  // Mean of the older buckets: (sum * 256) / (WINDOW_SLOTS - 1)
  // --------------------------------------------------------------------------
  logic             div_start;
  logic             hit_done, byte_done, div_done;
  logic [DIV_W-1:0] hit_quot, byte_quot;

  // The last rotate step carries the newest bucket: the sum is already final.
  assign div_start = (state_q == ST_SUM) && last_rot;
  assign div_done  = hit_done && byte_done;

  swrm_cdiv u_hit_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'({hit_acc_q, {FRAC_W{1'b0}}})),
    .done_o     (hit_done),
    .quotient_o (hit_quot)
  );

  swrm_cdiv u_byte_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'({byte_acc_q, {FRAC_W{1'b0}}})),
    .done_o     (byte_done),
    .quotient_o (byte_quot)
  );

  // Rate: the larger of the newest bucket and the older mean
  logic [HIT_RATE_W-1:0]  hit_new, hit_mean, hit_rate;
  logic [BYTE_RATE_W-1:0] byte_new, byte_mean, byte_rate;

  assign hit_new   = HIT_RATE_W'({hit_chain[0], {FRAC_W{1'b0}}});
  assign byte_new  = BYTE_RATE_W'({byte_chain[0], {FRAC_W{1'b0}}});
  assign hit_mean  = hit_quot[HIT_RATE_W-1:0];
  assign byte_mean = byte_quot[BYTE_RATE_W-1:0];
  assign hit_rate  = (hit_new > hit_mean) ? hit_new : hit_mean;
  assign byte_rate = (byte_new > byte_mean) ? byte_new : byte_mean;

  // --------------------------------------------------------------------------
  // Sequencer and result register
  // --------------------------------------------------------------------------
  logic load_out;

  // hold until the result register is free
  assign load_out = (state_q == ST_DIV) && div_done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      rot_q        <= '0;
      kind_q       <= 1'b0;
      size_q       <= '0;
      last_q       <= '0;
      hit_total_q  <= '0;
      byte_total_q <= '0;
      hit_acc_q    <= '0;
      byte_acc_q   <= '0;
      out_valid_q  <= 1'b0;
      hit_rate_q   <= '0;
      byte_rate_q  <= '0;
      tot_hits_q   <= '0;
      tot_bytes_q  <= '0;
    end else begin
      // load a new result, or drop the old one once the sink takes it
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_hs) begin
            kind_q <= in_i.kind;
            size_q <= in_i.byte_count;
            step_q <= age_steps;
            // an equal or earlier time keeps the last second
            if (later) last_q <= in_i.now_seconds;
            state_q <= (age_steps == '0) ? ST_HIT : ST_AGE;
          end
        end
        ST_AGE: begin
          step_q <= step_q - STEP_W'(1);
          if (step_q == STEP_W'(1)) state_q <= ST_HIT;
        end
        ST_HIT: begin
          if (!kind_q) begin
            hit_total_q  <= hit_total_q + TOTAL_W'(1);
            byte_total_q <= byte_total_q + TOTAL_W'(size_q);
          end
          rot_q      <= '0;
          hit_acc_q  <= '0;
          byte_acc_q <= '0;
          state_q    <= ST_SUM;
        end
        ST_SUM: begin
          if (last_rot) begin
            rot_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            hit_acc_q  <= hit_acc_q + HIT_SUM_W'(hit_chain[WINDOW_SLOTS-1]);
            byte_acc_q <= byte_acc_q + BYTE_SUM_W'(byte_chain[WINDOW_SLOTS-1]);
            rot_q      <= rot_q + SLOT_W'(1);
          end
        end
        ST_DIV: begin
          if (load_out) begin
            hit_rate_q  <= hit_rate;
            byte_rate_q <= byte_rate;
            tot_hits_q  <= hit_total_q;
            tot_bytes_q <= byte_total_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.hit_rate    = hit_rate_q;
  assign out_o.byte_rate   = byte_rate_q;
  assign out_o.total_hits  = tot_hits_q;
  assign out_o.total_bytes = tot_bytes_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SWRM_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_hs, state_q == ST_AGE || state_q == ST_HIT)
  `SWRM_ASSERT_IMP(a_age_nonzero, clk_i, rst_ni, state_q == ST_AGE, step_q != '0)
  `SWRM_ASSERT_IMP(a_result_from_div, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DIV && div_done))
  `SWRM_ASSERT_NXT(a_totals_hold, clk_i, rst_ni, state_q != ST_HIT, $stable(hit_total_q) && $stable(byte_total_q))

endmodule

`default_nettype wire
